// ----- hdl/scws_pkg.sv -----
// Shared constants, field widths and fixed-point helpers for the spring chain wave step block.
`default_nettype none

package scws_pkg;

    localparam int VAL_W    = 32;
    localparam int IDX_W    = 6;
    localparam int NUM_W    = 5;
    localparam int CNT_W    = 7;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;
    localparam int CFG_AW   = 2;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SPLASH = 1'b1;

    localparam logic [CFG_AW-1:0] REG_SURFACE_LEVEL  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_BOTTOM_LEVEL   = 2'd1;
    localparam logic [CFG_AW-1:0] REG_SPRINGS_IN_USE = 2'd2;

    localparam logic [CNT_W-1:0] MIN_SPRINGS = 7'd3;
    localparam logic [IDX_W-1:0] SPRINGS_RESET = 6'd32;

    localparam logic signed [15:0] STIFF_Q16 = 16'sd983;
    localparam logic signed [15:0] DAMP_Q16  = 16'sd3277;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [35:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > 36'(VAL_MAX)) begin
            r = VAL_MAX;
        end else if (v < 36'(VAL_MIN)) begin
            r = VAL_MIN;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    function automatic logic signed [VAL_W-1:0] rnd_q16(input logic signed [47:0] p);
        logic signed [47:0] t;
        t = p + 48'sd32768;
        return 32'(t >>> 16);
    endfunction

    function automatic logic signed [VAL_W-1:0] quarter(input logic signed [32:0] d);
        logic signed [33:0] t;
        t = 34'(d) + 34'sd2;
        return 32'(t >>> 2);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/spring_chain_wave_step_top.sv -----
// Top level of the spring chain wave step: sequencer, update pipeline and state RAMs.
//
//  channel | ports           | moves
//  --------+-----------------+----------------------------------------------
//  input   | s_tvalid/tready | tuser: opcode; tdata: spring_index, splash_speed
//  result  | m_tvalid/tready | tdata: spring_number, surface_height; tlast: last
//  config  | cfg_wr_en       | cfg_addr: register index; cfg_wdata: value
//
// A tick moves each spring through one read and one write of the height and speed
// RAMs, one spring per cycle through a five-stage update pipeline when results are
// taken at once.
// A result stalls the whole pipeline while the output register is full.
// Reset is synchronous, active low; per-entry valid bits make never-written
// entries read as zero, so no clearing pass follows reset.
`default_nettype none

module spring_chain_wave_step_top #(
    parameter int MAX_SPRINGS = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [scws_pkg::S_DATA_W-1:0]       s_tdata,   // [5:0] spring_index, [37:6] splash_speed
    input  wire logic                                s_tuser,   // [0] opcode
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [scws_pkg::M_DATA_W-1:0]       m_tdata,   // [4:0] spring_number, [36:5] surface_height
    output logic                                     m_tlast,
    input  wire logic                                cfg_wr_en,
    input  wire logic [scws_pkg::CFG_AW-1:0]         cfg_addr,
    input  wire logic [scws_pkg::VAL_W-1:0]          cfg_wdata
);

    localparam int IW = $clog2(MAX_SPRINGS);
    localparam int PAD_W = scws_pkg::M_DATA_W - scws_pkg::NUM_W - scws_pkg::VAL_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0] surface_reg, bottom_reg;
    logic [scws_pkg::IDX_W-1:0] springs_reg;

    logic [IW-1:0] issue_idx_reg, last_idx_reg;
    logic [MAX_SPRINGS-1:0] hval_reg, sval_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, cv_reg;
    logic [IW-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg, cidx_reg;
    logic last1_reg, last2_reg, last3_reg, last4_reg, clast_reg;
    logic hv1_reg, sv1_reg;
    logic signed [47:0] pk2_reg, pd2_reg;
    logic signed [31:0] s2_reg, h2_reg, s3_reg, h3_reg, s4_reg, h4_reg;
    logic signed [31:0] ch_reg, cs_reg, ph_reg;

    logic [scws_pkg::NUM_W-1:0] out_num_reg;
    logic signed [31:0] out_h_reg;
    logic out_last_reg, m_tvalid_reg;

    logic s_acc, tick_go, splash_go, adv, issue, fire, fire_go, pipe_empty;
    logic [scws_pkg::CNT_W-1:0] cnt_in, n_eff;
    logic [scws_pkg::IDX_W-1:0] s_idx;
    logic signed [31:0] s_speed;

    logic [31:0] h_rdata, s_rdata;
    logic signed [31:0] h1_w, s1_w;
    logic signed [32:0] dist_w;
    logic signed [47:0] pk_w, pd_w;
    logic signed [31:0] snew_w, hsum_w, hnew_w;
    logic signed [32:0] dprev_w, dnext_w;
    logic signed [31:0] qprev_w, qnext_w;
    logic signed [33:0] gain_w;
    logic signed [31:0] s_fin_w, h_gain_w, h_fin_w;

    logic spd_we;
    logic [IW-1:0] spd_waddr;
    logic [31:0] spd_wdata;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc = s_tvalid && s_tready;
    assign s_idx = s_tdata[scws_pkg::IDX_W-1:0];
    assign s_speed = $signed(s_tdata[scws_pkg::IDX_W +: scws_pkg::VAL_W]);

    assign cnt_in = {1'b0, springs_reg};
    assign n_eff = (cnt_in < scws_pkg::MIN_SPRINGS) ? scws_pkg::MIN_SPRINGS :
                   (cnt_in > scws_pkg::CNT_W'(MAX_SPRINGS)) ?
                   scws_pkg::CNT_W'(MAX_SPRINGS) : cnt_in;

    assign tick_go = s_acc && (s_tuser == scws_pkg::OP_TICK);
    assign splash_go = s_acc && (s_tuser == scws_pkg::OP_SPLASH)
                       && ({1'b0, s_idx} < n_eff);

    assign adv = !m_tvalid_reg || m_tready;
    assign issue = (state_reg == ST_RUN) && adv;
    assign fire = cv_reg && (v4_reg || clast_reg);
    assign fire_go = fire && adv;
    assign pipe_empty = !v1_reg && !v2_reg && !v3_reg && !v4_reg && !cv_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (tick_go) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (issue && issue_idx_reg == last_idx_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (pipe_empty) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // stage 1: RAM data, masked by valid bits, into the two products
    assign h1_w = hv1_reg ? $signed(h_rdata) : 32'sd0;
    assign s1_w = sv1_reg ? $signed(s_rdata) : 32'sd0;
    assign dist_w = 33'(h1_w) - 33'(surface_reg);
    assign pk_w = dist_w * scws_pkg::STIFF_Q16;
    assign pd_w = s1_w * scws_pkg::DAMP_Q16;

    // stage 2: new speed
    assign snew_w = scws_pkg::sat32(36'(s2_reg) - 36'(scws_pkg::rnd_q16(pk2_reg))
                                    - 36'(scws_pkg::rnd_q16(pd2_reg)));

    // stage 3: move and clamp
    assign hsum_w = scws_pkg::sat32(36'(h3_reg) + 36'(s3_reg));
    assign hnew_w = (hsum_w > bottom_reg) ? bottom_reg : hsum_w;

    // window: neighbor exchange for the center spring
    assign dprev_w = 33'(ph_reg) - 33'(ch_reg);
    assign dnext_w = 33'(h4_reg) - 33'(ch_reg);
    assign qprev_w = (cidx_reg != '0) ? scws_pkg::quarter(dprev_w) : 32'sd0;
    assign qnext_w = clast_reg ? 32'sd0 : scws_pkg::quarter(dnext_w);
    assign gain_w = 34'(qprev_w) + 34'(qnext_w);
    assign s_fin_w = scws_pkg::sat32(36'(cs_reg) + 36'(gain_w));
    assign h_gain_w = scws_pkg::sat32(36'(ch_reg) + 36'(gain_w));
    assign h_fin_w = (cidx_reg == '0 || clast_reg) ? surface_reg : h_gain_w;

    assign spd_we = fire_go || splash_go;
    assign spd_waddr = fire_go ? cidx_reg : s_idx[IW-1:0];
    assign spd_wdata = fire_go ? s_fin_w : s_speed;

    scws_ram #(.WIDTH(scws_pkg::VAL_W), .DEPTH(MAX_SPRINGS)) u_height_ram (
        .aclk    (aclk),
        .wr_en   (fire_go),
        .wr_addr (cidx_reg),
        .wr_data (h_fin_w),
        .rd_en   (issue),
        .rd_addr (issue_idx_reg),
        .rd_data (h_rdata)
    );

    scws_ram #(.WIDTH(scws_pkg::VAL_W), .DEPTH(MAX_SPRINGS)) u_speed_ram (
        .aclk    (aclk),
        .wr_en   (spd_we),
        .wr_addr (spd_waddr),
        .wr_data (spd_wdata),
        .rd_en   (issue),
        .rd_addr (issue_idx_reg),
        .rd_data (s_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            surface_reg   <= '0;
            bottom_reg    <= scws_pkg::VAL_MAX;
            springs_reg   <= scws_pkg::SPRINGS_RESET;
            issue_idx_reg <= '0;
            hval_reg      <= '0;
            sval_reg      <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            cv_reg        <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    scws_pkg::REG_SURFACE_LEVEL:  surface_reg <= $signed(cfg_wdata);
                    scws_pkg::REG_BOTTOM_LEVEL:   bottom_reg  <= $signed(cfg_wdata);
                    scws_pkg::REG_SPRINGS_IN_USE: springs_reg <= cfg_wdata[scws_pkg::IDX_W-1:0];
                    default: ;
                endcase
            end
            if (tick_go) begin
                issue_idx_reg <= '0;
            end else if (issue) begin
                issue_idx_reg <= issue_idx_reg + 1'b1;
            end
            if (adv) begin
                v1_reg <= issue;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                if (v4_reg) begin
                    cv_reg <= 1'b1;
                end else if (fire) begin
                    cv_reg <= 1'b0;
                end
                m_tvalid_reg <= fire;
            end
            if (fire_go) begin
                hval_reg[cidx_reg] <= 1'b1;
                sval_reg[cidx_reg] <= 1'b1;
            end
            if (splash_go) begin
                sval_reg[s_idx[IW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_go) begin
            last_idx_reg <= IW'(n_eff - 1'b1);
        end
        if (adv) begin
            idx1_reg  <= issue_idx_reg;
            last1_reg <= (issue_idx_reg == last_idx_reg);
            hv1_reg   <= hval_reg[issue_idx_reg];
            sv1_reg   <= sval_reg[issue_idx_reg];

            pk2_reg   <= pk_w;
            pd2_reg   <= pd_w;
            s2_reg    <= s1_w;
            h2_reg    <= h1_w;
            idx2_reg  <= idx1_reg;
            last2_reg <= last1_reg;

            s3_reg    <= snew_w;
            h3_reg    <= h2_reg;
            idx3_reg  <= idx2_reg;
            last3_reg <= last2_reg;

            s4_reg    <= s3_reg;
            h4_reg    <= hnew_w;
            idx4_reg  <= idx3_reg;
            last4_reg <= last3_reg;

            if (v4_reg) begin
                ph_reg    <= ch_reg;
                ch_reg    <= h4_reg;
                cs_reg    <= s4_reg;
                cidx_reg  <= idx4_reg;
                clast_reg <= last4_reg;
            end
            if (fire) begin
                out_num_reg  <= scws_pkg::NUM_W'(cidx_reg);
                out_h_reg    <= h_fin_w;
                out_last_reg <= clast_reg;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {{PAD_W{1'b0}}, out_h_reg, out_num_reg};
    assign m_tlast = out_last_reg;

endmodule

`default_nettype wire

// ----- hdl/scws_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module scws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/scws_check.sv -----
// Port-level checker for the spring chain wave step top, bound to every instance.
`default_nettype none

module scws_check (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [scws_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                          m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_busy_after_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == scws_pkg::OP_TICK |=> !s_tready)
        else $error("input still open after a tick transfer");

    a_splash_stays_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == scws_pkg::OP_SPLASH |=> s_tready)
        else $error("splash transfer made the block busy");

    a_result_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !s_tready)
        else $error("new result appeared while idle");

endmodule

bind spring_chain_wave_step_top scws_check u_scws_check (.*);

`default_nettype wire

// ----- dv/spring_chain_wave_step_top_test.sv -----
// Self-checking testbench for spring_chain_wave_step_top: predicts every reported spring height.
module spring_chain_wave_step_top_test;
    import scws_pkg::*;

    localparam int MAX_SPRINGS = 32;
    localparam longint STIFFNESS = 983;
    localparam longint DAMPING = 3277;
    localparam logic [CFG_AW-1:0] REG_SPARE = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES = 2 * MAX_SPRINGS + 12;
    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_ITEMS = 31;

    typedef struct packed {
        logic [NUM_W-1:0]        number;
        logic signed [VAL_W-1:0] level;
        logic                    last;
    } height_report_t;

    class wave_scoreboard;
        int surface;
        int bottom;
        logic [IDX_W-1:0] springs_reg;
        int height [MAX_SPRINGS];
        int speed [MAX_SPRINGS];
        height_report_t height_reports [$];
        int errors;

        function new();
            surface = 0;
            bottom = VAL_MAX;
            springs_reg = SPRINGS_RESET;
            foreach (height[i]) begin
                height[i] = 0;
                speed[i] = 0;
            end
            errors = 0;
        endfunction

        function int active_springs();
            if (springs_reg < MIN_SPRINGS) return int'(MIN_SPRINGS);
            if (springs_reg > MAX_SPRINGS) return MAX_SPRINGS;
            return int'(springs_reg);
        endfunction

        function int clip_word(longint v);
            if (v > longint'(VAL_MAX)) return VAL_MAX;
            if (v < longint'(VAL_MIN)) return VAL_MIN;
            return int'(v);
        endfunction

        function longint scale_q16(longint v, longint coeff);
            return (v * coeff + 32768) >>> 16;
        endfunction

        function longint quarter_of(longint diff);
            return (diff + 2) >>> 2;
        endfunction

        function void write_reg(logic [CFG_AW-1:0] addr, logic [VAL_W-1:0] value);
            case (addr)
                REG_SURFACE_LEVEL:  surface = value;
                REG_BOTTOM_LEVEL:   bottom = value;
                REG_SPRINGS_IN_USE: springs_reg = value[IDX_W-1:0];
                default: ;
            endcase
        endfunction

        function void advance_chain();
            int n;
            int settled;
            longint v;
            longint gain;
            int before_share [MAX_SPRINGS];
            height_report_t rep;
            n = active_springs();
            for (int i = 0; i < n; i++) begin
                v = longint'(speed[i])
                    - scale_q16(longint'(height[i]) - longint'(surface), STIFFNESS)
                    - scale_q16(longint'(speed[i]), DAMPING);
                speed[i] = clip_word(v);
                settled = clip_word(longint'(height[i]) + longint'(speed[i]));
                height[i] = (settled > bottom) ? bottom : settled;
            end
            for (int i = 0; i < n; i++) before_share[i] = height[i];
            for (int i = 0; i < n; i++) begin
                gain = 0;
                if (i > 0)
                    gain += quarter_of(longint'(before_share[i-1]) - longint'(before_share[i]));
                if (i < n - 1)
                    gain += quarter_of(longint'(before_share[i+1]) - longint'(before_share[i]));
                speed[i] = clip_word(longint'(speed[i]) + gain);
                height[i] = clip_word(longint'(height[i]) + gain);
            end
            height[0] = surface;
            height[n-1] = surface;
            for (int i = 0; i < n; i++) begin
                rep.number = NUM_W'(i);
                rep.level = height[i];
                rep.last = (i == n - 1);
                height_reports.insert(height_reports.size(), rep);
            end
        endfunction

        function void note_input(logic opcode, logic [IDX_W-1:0] idx,
                                 logic [VAL_W-1:0] new_speed);
            if (opcode == OP_SPLASH) begin
                if (int'(idx) < active_springs()) speed[idx] = new_speed;
            end else begin
                advance_chain();
            end
        endfunction

        function void check_result(logic [NUM_W-1:0] number, logic signed [VAL_W-1:0] level,
                                   logic last);
            height_report_t want;
            if (height_reports.size() == 0) begin
                errors++;
                $error("unexpected transfer: spring_number %0d surface_height %0d", number, level);
            end else begin
                want = height_reports.pop_front();
                if (number !== want.number) begin
                    errors++;
                    $error("spring_number: expected %0d, got %0d", want.number, number);
                end
                if (level !== want.level) begin
                    errors++;
                    $error("surface_height: expected %0d, got %0d", want.level, level);
                end
                if (last !== want.last) begin
                    errors++;
                    $error("last: expected %0b, got %0b", want.last, last);
                end
            end
        endfunction

        function int outstanding();
            return height_reports.size();
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0]   cfg_addr = '0;
    logic [VAL_W-1:0]    cfg_wdata = '0;

    bit steady = 1'b0;
    int hold_request = 0;
    wave_scoreboard scoreboard;

    spring_chain_wave_step_top #(
        .MAX_SPRINGS(MAX_SPRINGS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [VAL_W-1:0] pick_speed();
        int roll;
        roll = $urandom_range(99);
        if (roll < 20) return $urandom;
        if (roll < 28) return VAL_MAX;
        if (roll < 36) return VAL_MIN;
        return $urandom_range(4194304) - 32'd2097152;
    endfunction

    task automatic send_item(input logic opcode, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] value);
        while (!steady && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= opcode;
        s_tdata <= {{(S_DATA_W - IDX_W - VAL_W){1'b0}}, value, idx};
        do @(posedge aclk); while (!s_tready);
        scoreboard.note_input(opcode, idx, value);
    endtask

    task automatic random_item();
        int n;
        logic [IDX_W-1:0] idx;
        n = scoreboard.active_springs();
        if ($urandom_range(99) < 45) begin
            send_item(OP_TICK, IDX_W'($urandom), pick_speed());
        end else begin
            if ($urandom_range(99) < 85) idx = IDX_W'($urandom_range(n - 1));
            else idx = IDX_W'($urandom);
            send_item(OP_SPLASH, idx, pick_speed());
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (scoreboard.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic issue_write(input logic [CFG_AW-1:0] addr, input logic [VAL_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        scoreboard.write_reg(addr, value);
    endtask

    task automatic load_settings(input logic [VAL_W-1:0] surf, input logic [VAL_W-1:0] bot,
                                 input logic [VAL_W-1:0] count_word, input bit touch_spare);
        issue_write(REG_SURFACE_LEVEL, surf);
        issue_write(REG_BOTTOM_LEVEL, bot);
        issue_write(REG_SPRINGS_IN_USE, count_word);
        if (touch_spare) issue_write(REG_SPARE, $urandom);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                scoreboard.check_result(m_tdata[NUM_W-1:0], m_tdata[NUM_W+VAL_W-1:NUM_W],
                                        m_tlast);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 22);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("spring_chain_wave_step_top verification failed");
        $finish;
    end

    initial begin : stimulus
        int phase;
        logic [VAL_W-1:0] surf;
        logic [VAL_W-1:0] bot;
        logic [VAL_W-1:0] count_word;
        scoreboard = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings; splashes beyond the spring count are dropped
        send_item(OP_SPLASH, 6'd0, VAL_MAX);
        send_item(OP_SPLASH, 6'd31, VAL_MIN);
        send_item(OP_SPLASH, 6'd32, 32'h0000_1234);
        send_item(OP_SPLASH, 6'd63, VAL_MAX);
        send_item(OP_SPLASH, 6'd10, 32'h0005_0000);
        send_item(OP_TICK, 6'd0, 32'h0000_0000);
        send_item(OP_TICK, 6'd63, 32'hFFFF_FFFF);
        send_item(OP_SPLASH, 6'd20, 32'hFFFD_0000);
        send_item(OP_TICK, 6'd0, 32'h0000_0000);
        settle();

        // count below the minimum, floor under the surface, spare register poked
        load_settings(32'h0010_0000, 32'h0008_0000, 32'd0, 1'b1);
        send_item(OP_SPLASH, 6'd1, 32'h0002_0000);
        send_item(OP_SPLASH, 6'd3, VAL_MAX);
        send_item(OP_TICK, 6'd0, 32'h0000_0000);
        send_item(OP_TICK, 6'd0, 32'h0000_0000);
        send_item(OP_SPLASH, 6'd2, VAL_MIN);
        send_item(OP_TICK, 6'd0, 32'h0000_0000);
        settle();

        load_settings(VAL_MIN, VAL_MIN, 32'd63, 1'b0);
        send_item(OP_SPLASH, 6'd31, VAL_MAX);
        send_item(OP_SPLASH, 6'd62, 32'h0000_0007);
        send_item(OP_TICK, 6'd0, 32'h0000_0000);
        send_item(OP_TICK, 6'd0, 32'h0000_0000);
        settle();

        load_settings(VAL_MAX, VAL_MAX, 32'd33, 1'b0);
        send_item(OP_SPLASH, 6'd16, VAL_MIN);
        send_item(OP_TICK, 6'd0, 32'h0000_0000);
        send_item(OP_TICK, 6'd0, 32'h0000_0000);
        settle();

        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    surf = '0;
                    bot = VAL_MAX;
                    count_word = 32'd32;
                end
                1: begin
                    surf = $urandom_range(2097152) - 32'd1048576;
                    bot = surf + $urandom_range(262144);
                    count_word = $urandom_range(MAX_SPRINGS, 3);
                end
                2: begin
                    surf = VAL_MIN;
                    bot = VAL_MAX;
                    count_word = 32'd63;
                    steady = 1'b1;
                end
                3: begin
                    surf = VAL_MAX;
                    bot = VAL_MIN;
                    count_word = 32'd0;
                end
                4: begin
                    surf = $urandom;
                    bot = $urandom;
                    count_word = $urandom;
                end
                default: begin
                    surf = 32'd0 - $urandom_range(1048576);
                    bot = $urandom_range(262144);
                    count_word = 32'd3;
                end
            endcase
            load_settings(surf, bot, count_word, phase == 3);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (phase == 0 && k == 6) hold_request = HOLD_CYCLES;
                random_item();
            end
            settle();
            steady = 1'b0;
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (scoreboard.errors == 0 && scoreboard.outstanding() == 0)
            $display("spring_chain_wave_step_top verification clean");
        else
            $display("spring_chain_wave_step_top verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/scws_pkg.sv
hdl/scws_ram.sv
hdl/spring_chain_wave_step_top.sv
hdl/scws_check.sv
dv/spring_chain_wave_step_top_test.sv
